// ===== src/blid_pkg.sv =====
// Shared types and codes for the bounded list with indexed delete.
package blid_pkg;

    localparam int unsigned DATA_W = 32;

    // operation codes
    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [1:0] OP_DELETE     = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] operand;
    } in_item_t;

    typedef struct packed {
        logic                     direction;
        logic signed [DATA_W-1:0] element;
        logic                     is_empty;
        logic                     end_of_direction;
        logic                     last;
        logic [1:0]               status;
    } out_item_t;

    // tags that travel with one listing read
    typedef struct packed {
        logic       direction;
        logic       is_empty;
        logic       end_of_direction;
        logic       last;
        logic [1:0] status;
    } list_meta_t;

endpackage

// ===== src/blid_step_unit.sv =====
// Shared address stepper: one increment/decrement and one end compare.
module blid_step_unit #(
    parameter int unsigned AW = 4
) (
    input  logic [AW-1:0] addr,
    input  logic          down,
    input  logic [AW-1:0] limit,
    output logic [AW-1:0] next_addr,
    output logic          hit
);
    always_comb
    begin
        next_addr = down ? (addr - AW'(1)) : (addr + AW'(1));
        hit       = (addr == limit);
    end
endmodule

// ===== src/blid_out_stage.sv =====
// Output register fed from the registered list read, one beat per cycle unless stalled.
module blid_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   issue,
    input  blid_pkg::list_meta_t   meta_in,
    input  logic [31:0]            rd_data,
    output logic                   credit,
    output logic                   pending,
    output blid_pkg::out_item_t    result,
    output logic                   result_valid,
    input  logic                   result_ready
);
    import blid_pkg::*;

    logic       pend_reg, pend_next;
    list_meta_t meta_reg;
    out_item_t  out_reg;
    logic       out_valid_reg, out_valid_next;
    logic       ld;

    // pending read data moves on when the output slot is free or drains now
    assign ld      = pend_reg && (!out_valid_reg || result_ready);
    assign credit  = !pend_reg || ld;
    assign pending = pend_reg;

    always_comb
    begin
        pend_next = pend_reg;
        if (issue)
        begin
            pend_next = 1'b1;
        end
        else if (ld)
        begin
            pend_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (ld)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            meta_reg <= meta_in;
        end
        if (ld)
        begin
            out_reg.direction        <= meta_reg.direction;
            out_reg.element          <= meta_reg.is_empty ? '0 : rd_data;
            out_reg.is_empty         <= meta_reg.is_empty;
            out_reg.end_of_direction <= meta_reg.end_of_direction;
            out_reg.last             <= meta_reg.last;
            out_reg.status           <= meta_reg.status;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;
endmodule

// ===== src/bounded_list_indexed_delete_core.sv =====
// Bounded ordered list of signed words with push front, push back and indexed delete; after
// every operation it lists the whole list head-to-tail and then tail-to-head. One item at a
// time: item_ready is high only while idle. Entries live in a one-write, one-read memory and
// are moved one per cycle through a single address stepper. An item's listing has 2n' beats
// (n' the count after the operation), or 2 when the list ends empty. Before it, a push that
// stores writes its operand, a push front into a non-empty list first shifts every entry up,
// and a delete below the last entry first shifts the entries above it down. Beats stream one
// per cycle when result_ready stays high. Opcode 3 is taken and gives no beats.
module bounded_list_indexed_delete_core #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  blid_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output blid_pkg::out_item_t result
);
    import blid_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_INS   = 2'd2;
    localparam logic [1:0] S_LIST  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    status_reg, status_next;
    logic [31:0]   operand_reg;
    logic          front_reg, front_next;

    // shift sequencer
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [AW-1:0] rd_end_reg, rd_end_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [AW-1:0] prev_addr_reg, prev_addr_next;
    logic          prev_valid_reg, prev_valid_next;
    logic          rd_done_reg, rd_done_next;
    logic          shift_down_reg, shift_down_next;

    // listing sequencer
    logic          li_dir_reg, li_dir_next;
    logic [AW-1:0] li_idx_reg, li_idx_next;
    logic          li_done_reg, li_done_next;

    // memory
    logic [31:0]   mem [CAPACITY];
    logic [31:0]   rd_data_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [31:0]   mem_wd;

    // stepper
    logic [AW-1:0] su_addr, su_limit, su_next;
    logic          su_down, su_hit;

    logic          accept, empty, full, pos_ok, eod;
    logic [AW-1:0] last_idx, pos;
    logic          issue, credit, pending;
    list_meta_t    meta;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign empty      = (count_reg == '0);
    assign full       = (count_reg == CW'(CAPACITY));
    assign last_idx   = AW'(count_reg - CW'(1));
    assign pos        = item.operand[AW-1:0];
    // negative positions have the sign bit set and never compare below the count
    assign pos_ok     = ($unsigned(item.operand) < 32'(count_reg));

    always_comb
    begin
        if (state_reg == S_LIST)
        begin
            su_addr  = li_idx_reg;
            su_down  = li_dir_reg;
            su_limit = li_dir_reg ? '0 : last_idx;
        end
        else
        begin
            su_addr  = rd_addr_reg;
            su_down  = shift_down_reg;
            su_limit = rd_end_reg;
        end
    end

    blid_step_unit #(
        .AW (AW)
    ) u_step (
        .addr      (su_addr),
        .down      (su_down),
        .limit     (su_limit),
        .next_addr (su_next),
        .hit       (su_hit)
    );

    assign eod = su_hit || empty;

    always_comb
    begin
        meta.direction        = li_dir_reg;
        meta.is_empty         = empty;
        meta.end_of_direction = eod;
        meta.last             = li_dir_reg && eod;
        meta.status           = status_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        front_next      = front_reg;
        rd_addr_next    = rd_addr_reg;
        rd_end_next     = rd_end_reg;
        wr_addr_next    = wr_addr_reg;
        prev_addr_next  = prev_addr_reg;
        prev_valid_next = prev_valid_reg;
        rd_done_next    = rd_done_reg;
        shift_down_next = shift_down_reg;
        li_dir_next     = li_dir_reg;
        li_idx_next     = li_idx_reg;
        li_done_next    = li_done_reg;
        mem_we          = 1'b0;
        mem_wa          = wr_addr_reg;
        mem_wd          = rd_data_reg;
        mem_re          = 1'b0;
        mem_ra          = rd_addr_reg;
        issue           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                li_dir_next    = 1'b0;
                li_idx_next    = '0;
                li_done_next   = 1'b0;
                prev_valid_next = 1'b0;
                rd_done_next   = 1'b0;
                status_next    = ST_DONE;
                if (accept)
                begin
                    unique case (item.op)
                        OP_PUSH_FRONT:
                        begin
                            front_next = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_LIST;
                            end
                            else if (empty)
                            begin
                                wr_addr_next = '0;
                                state_next   = S_INS;
                            end
                            else
                            begin
                                rd_addr_next    = last_idx;
                                wr_addr_next    = AW'(count_reg);
                                rd_end_next     = '0;
                                shift_down_next = 1'b1;
                                state_next      = S_SHIFT;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            front_next = 1'b0;
                            if (full)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_LIST;
                            end
                            else
                            begin
                                wr_addr_next = AW'(count_reg);
                                state_next   = S_INS;
                            end
                        end
                        OP_DELETE:
                        begin
                            front_next = 1'b0;
                            if (!pos_ok)
                            begin
                                status_next = ST_IGNORED;
                                state_next  = S_LIST;
                            end
                            else if (pos == last_idx)
                            begin
                                count_next = count_reg - CW'(1);
                                state_next = S_LIST;
                            end
                            else
                            begin
                                rd_addr_next    = pos + AW'(1);
                                wr_addr_next    = pos;
                                rd_end_next     = last_idx;
                                shift_down_next = 1'b0;
                                state_next      = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // read one entry ahead, write the previous read to its new place
                if (prev_valid_reg)
                begin
                    mem_we       = 1'b1;
                    wr_addr_next = prev_addr_reg;
                end
                if (!rd_done_reg)
                begin
                    mem_re          = 1'b1;
                    prev_valid_next = 1'b1;
                    prev_addr_next  = rd_addr_reg;
                    if (su_hit)
                    begin
                        rd_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_addr_next = su_next;
                    end
                end
                else
                begin
                    prev_valid_next = 1'b0;
                    if (prev_valid_reg)
                    begin
                        if (front_reg)
                        begin
                            wr_addr_next = '0;
                            state_next   = S_INS;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_LIST;
                        end
                    end
                end
            end

            S_INS:
            begin
                mem_we     = 1'b1;
                mem_wd     = operand_reg;
                count_next = count_reg + CW'(1);
                state_next = S_LIST;
            end

            S_LIST:
            begin
                mem_ra = li_idx_reg;
                if (!li_done_reg && credit)
                begin
                    mem_re = 1'b1;
                    issue  = 1'b1;
                    if (eod)
                    begin
                        if (li_dir_reg)
                        begin
                            li_done_next = 1'b1;
                        end
                        else
                        begin
                            li_dir_next = 1'b1;
                        end
                    end
                    else
                    begin
                        li_idx_next = su_next;
                    end
                end
                if (li_done_reg && !pending)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            status_reg     <= ST_DONE;
            front_reg      <= 1'b0;
            prev_valid_reg <= 1'b0;
            rd_done_reg    <= 1'b0;
            shift_down_reg <= 1'b0;
            li_dir_reg     <= 1'b0;
            li_done_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            status_reg     <= status_next;
            front_reg      <= front_next;
            prev_valid_reg <= prev_valid_next;
            rd_done_reg    <= rd_done_next;
            shift_down_reg <= shift_down_next;
            li_dir_reg     <= li_dir_next;
            li_done_reg    <= li_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            operand_reg <= item.operand;
        end
        rd_addr_reg   <= rd_addr_next;
        rd_end_reg    <= rd_end_next;
        wr_addr_reg   <= wr_addr_next;
        prev_addr_reg <= prev_addr_next;
        li_idx_reg    <= li_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    blid_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (issue),
        .meta_in      (meta),
        .rd_data      (rd_data_reg),
        .credit       (credit),
        .pending      (pending),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );
endmodule

// ===== src/blid_checker.sv =====
// Port-level checks for the bounded list core, bound to the core module.
module blid_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input blid_pkg::out_item_t result
);
    import blid_pkg::*;

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_empty |-> result.end_of_direction && result.element == '0)
        else $error("empty marker malformed");

    a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> result.direction && result.end_of_direction)
        else $error("last beat not at end of reverse listing");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_FULL |-> !result.is_empty)
        else $error("full status on empty listing");

    // no new item is taken while a beat other than the item's last beat is still waiting
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> !item_ready)
        else $error("ready while listing in flight");
endmodule

bind bounded_list_indexed_delete_core blid_checker u_blid_checker (.*);

// ===== verif/tb_top.sv =====
// Testbench for the bounded list core: directed and random list operations, checked per beat.
module tb_top;
    import blid_pkg::*;

    localparam int unsigned CAPACITY    = 16;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          STALL_LIMIT = 4000;
    localparam int          TAIL_CYCLES = 64;
    localparam int          HOLD_CYCLES = 400;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    // list model and the beats it predicts
    logic signed [DATA_W-1:0] list_vals [CAPACITY];
    int unsigned              list_count = 0;
    out_item_t                listing_q [$];

    int errors         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    bounded_list_indexed_delete_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always #4 clk = ~clk;

    function automatic out_item_t make_beat(input logic dir, input logic signed [DATA_W-1:0] elem,
                                            input logic empty, input logic eod,
                                            input logic fin, input logic [1:0] st);
        out_item_t b;
        b.direction        = dir;
        b.element          = elem;
        b.is_empty         = empty;
        b.end_of_direction = eod;
        b.last             = fin;
        b.status           = st;
        return b;
    endfunction

    // append one predicted beat at the tail of the queue
    task automatic queue_beat(input out_item_t b);
        listing_q = {listing_q, b};
    endtask

    // apply one accepted operation to the list model and queue the listing it causes
    task automatic predict_listing(input in_item_t it);
        logic [1:0]  st;
        int unsigned pos;
        st = ST_DONE;
        case (it.op)
            OP_PUSH_FRONT:
                if (list_count >= CAPACITY)
                    st = ST_FULL;
                else
                begin
                    for (int i = list_count; i > 0; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[0] = it.operand;
                    list_count++;
                end
            OP_PUSH_BACK:
                if (list_count >= CAPACITY)
                    st = ST_FULL;
                else
                begin
                    list_vals[list_count] = it.operand;
                    list_count++;
                end
            OP_DELETE:
            begin
                // negative positions read as huge unsigned ones
                pos = it.operand;
                if (pos >= list_count)
                    st = ST_IGNORED;
                else
                begin
                    for (int i = pos; i + 1 < list_count; i++)
                        list_vals[i] = list_vals[i+1];
                    list_count--;
                end
            end
            default:
                return;
        endcase

        if (list_count == 0)
        begin
            queue_beat(make_beat(1'b0, '0, 1'b1, 1'b1, 1'b0, st));
            queue_beat(make_beat(1'b1, '0, 1'b1, 1'b1, 1'b1, st));
        end
        else
        begin
            for (int i = 0; i < list_count; i++)
                queue_beat(make_beat(1'b0, list_vals[i], 1'b0,
                                     i + 1 == list_count, 1'b0, st));
            for (int i = list_count; i > 0; i--)
                queue_beat(make_beat(1'b1, list_vals[i-1], 1'b0,
                                     i == 1, i == 1, st));
        end
    endtask

    // grow runs favor pushes, shrink runs favor deletes at live positions
    function automatic in_item_t rand_list_op(input bit grow);
        in_item_t    it;
        int unsigned pick;
        pick       = $urandom_range(99);
        it.operand = $urandom;
        if (pick < 4)
            it.op = OP_UNUSED;
        else if (pick < (grow ? 70 : 30))
            it.op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else
        begin
            it.op = OP_DELETE;
            pick  = $urandom_range(9);
            if (list_count != 0 && pick < 7)
                it.operand = $urandom_range(list_count - 1);
            else if (pick < 8)
                it.operand = list_count + $urandom_range(2);
        end
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        predict_listing(it);
    endtask

    task automatic send_op(input logic [1:0] op, input logic signed [DATA_W-1:0] operand);
        in_item_t it;
        it.op      = op;
        it.operand = operand;
        send_item(it);
    endtask

    task automatic drain_listing();
        item_valid <= 1'b0;
        while (listing_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic test_empty_list();
        send_op(OP_DELETE, 0);
        send_op(OP_UNUSED, 32'h7fff_ffff);
    endtask

    task automatic test_extreme_values();
        send_op(OP_PUSH_BACK, 32'h7fff_ffff);
        send_op(OP_PUSH_FRONT, 32'h8000_0000);
        send_op(OP_PUSH_BACK, 0);
        send_op(OP_PUSH_FRONT, -1);
        send_op(OP_DELETE, 4);
        send_op(OP_DELETE, 32'h7fff_ffff);
        send_op(OP_DELETE, -1);
        send_op(OP_DELETE, 0);
        send_op(OP_DELETE, 2);
    endtask

    task automatic test_full_list();
        while (list_count < CAPACITY)
            send_op($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom);
        send_op(OP_PUSH_FRONT, $urandom);
        send_op(OP_PUSH_BACK, $urandom);
        send_op(OP_DELETE, CAPACITY / 2 - 1);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_ops);
        int       sent;
        int       run_left;
        bit       grow;
        in_item_t it;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent     = 0;
        run_left = 0;
        grow     = 1'b0;
        while (sent < n_ops)
        begin
            if (run_left == 0)
            begin
                grow     = ~grow;
                run_left = $urandom_range(30, 10);
            end
            it = rand_list_op(grow);
            send_item(it);
            if (it.op != OP_UNUSED)
            begin
                sent++;
                run_left--;
            end
        end
    endtask

    // receiver shuts off for a long stretch while items keep coming, then full drain
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        repeat (6)
            send_item(rand_list_op(1'b1));
        drain_listing();
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            result_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (listing_q.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, got %h", $time, result);
                errors++;
            end
            else
            begin
                want = listing_q.pop_front();
                check_field("direction", 32'(want.direction), 32'(result.direction));
                check_field("element", want.element, result.element);
                check_field("is_empty", 32'(want.is_empty), 32'(result.is_empty));
                check_field("end_of_direction", 32'(want.end_of_direction),
                            32'(result.end_of_direction));
                check_field("last", 32'(want.last), 32'(result.last));
                check_field("status", 32'(want.status), 32'(result.status));
            end
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_extreme_values();
        test_full_list();
        test_random_traffic(0, 0, 88);
        test_random_traffic(84, 0, 88);
        test_random_traffic(0, 84, 88);
        test_random_traffic(10, 10, 88);
        test_backpressure();
        drain_listing();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
